// ===== rtl/cdq_pkg.sv =====
// Types and constants shared by the circular deque and its checker.
`timescale 1ns / 1ps
package cdq_pkg;

  localparam int unsigned CapW     = 11;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned ActionW  = 3;
  localparam int unsigned InDataW  = 40;  // action + value, padded to bytes
  localparam int unsigned OutDataW = 72;  // ok, front, rear, empty, full, padded
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // Bit positions in the result word
  localparam int unsigned OutOkBit    = 0;
  localparam int unsigned OutFrontLsb = 1;
  localparam int unsigned OutRearLsb  = 33;
  localparam int unsigned OutEmptyBit = 65;
  localparam int unsigned OutFullBit  = 66;

  localparam logic [ValueW-1:0] EmptyValue = '1;  // -1 shown while empty

  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_NOP        = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DONE = 2'b10
  } state_e;

  // Result of the accept cycle, finished once the memory read returns
  typedef struct packed {
    logic ok;
    logic front_from_mem;
    logic rear_from_mem;
  } pend_t;

endpackage

// ===== rtl/circular_deque_top.sv =====
// Circular deque: top level with the word store, indices and stream ports.
`timescale 1ns / 1ps
// A double-ended queue of DATA_WIDTH-bit words in a single-port-write,
// single-read synchronous memory of DEPTH entries. Each input word carries an
// action (push front, push back, pop front, pop back, no operation); each
// produces one result word with the success flag, front and rear words (-1
// while empty) and the empty and full flags. For each item, the accept cycle
// updates the indices and writes or reads the memory; after it, the DONE
// state collects the registered memory read data into the output register
// once the output side is free. No new item is taken until then. A waiting
// result in the output register does not block the next accept.
// Front and rear words are cached in registers; a pop reads the one new end
// word from memory. Writing capacity empties the deque; a capacity of zero
// acts as one and values above DEPTH act as DEPTH.
module circular_deque_top #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cdq_pkg::InDataW-1:0]   s_axis_tdata,  // action[2:0], value[34:3]
  // stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [cdq_pkg::OutDataW-1:0]  m_axis_tdata,  // ok[0], front[32:1],
                                                       // rear[64:33], empty[65],
                                                       // full[66]
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cdq_pkg::CfgAddrW-1:0]  paddr,
  input  logic [cdq_pkg::CfgDataW-1:0]  pwdata,
  output logic [cdq_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import cdq_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_e                 state_q, state_d;
  logic [CapW-1:0]        capacity_q;
  logic [IdxW-1:0]        cap_m1;
  logic [IdxW-1:0]        head_q, head_d, tail_q, tail_d;
  logic                   empty_q, empty_d;
  logic [DATA_WIDTH-1:0]  front_q, front_d, rear_q, rear_d;
  pend_t                  pend_q, pend_d;
  logic                   m_tvalid_q;
  logic [OutDataW-1:0]    m_tdata_q, m_tdata_d;

  logic [DATA_WIDTH-1:0]  mem_q [DEPTH];
  logic [DATA_WIDTH-1:0]  rd_data_q;
  logic                   mem_we, mem_re;
  logic [IdxW-1:0]        mem_wa, mem_ra;

  logic                   cfg_we, accept, out_free, load_out;
  action_e                action;
  logic [DATA_WIDTH-1:0]  in_word;
  logic [IdxW-1:0]        head_up, head_dn, tail_up, tail_dn;
  logic                   full_now;
  logic signed [DATA_WIDTH-1:0] front_sel, rear_sel;
  logic signed [63:0]     front_ext, rear_ext;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : CfgDataW'(capacity_q);

  // Last index in use
  always_comb begin
    if (capacity_q == '0) begin
      cap_m1 = '0;
    end else if (32'(capacity_q) > DEPTH) begin
      cap_m1 = IdxW'(DEPTH - 1);
    end else begin
      cap_m1 = IdxW'(capacity_q - 1'b1);
    end
  end

  assign head_up  = (head_q == cap_m1) ? '0 : head_q + 1'b1;
  assign head_dn  = (head_q == '0) ? cap_m1 : head_q - 1'b1;
  assign tail_up  = (tail_q == cap_m1) ? '0 : tail_q + 1'b1;
  assign tail_dn  = (tail_q == '0) ? cap_m1 : tail_q - 1'b1;
  assign full_now = !empty_q && (tail_up == head_q);

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign action        = action_e'(s_axis_tdata[2:0]);
  assign in_word       = DATA_WIDTH'(s_axis_tdata[34:3]);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    front_d = front_q;
    rear_d  = rear_q;
    pend_d  = pend_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    mem_wa  = '0;
    mem_ra  = '0;
    if (accept) begin
      pend_d = '0;
      case (action)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (empty_q) begin
            head_d    = '0;
            tail_d    = '0;
            empty_d   = 1'b0;
            front_d   = in_word;
            rear_d    = in_word;
            mem_we    = 1'b1;
            pend_d.ok = 1'b1;
          end else if (!full_now) begin
            mem_we    = 1'b1;
            pend_d.ok = 1'b1;
            if (action == ACT_PUSH_FRONT) begin
              head_d  = head_dn;
              mem_wa  = head_dn;
              front_d = in_word;
            end else begin
              tail_d  = tail_up;
              mem_wa  = tail_up;
              rear_d  = in_word;
            end
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          if (!empty_q) begin
            pend_d.ok = 1'b1;
            if (head_q == tail_q) begin
              head_d  = '0;
              tail_d  = '0;
              empty_d = 1'b1;
            end else if (action == ACT_POP_FRONT) begin
              head_d  = head_up;
              mem_re  = 1'b1;
              mem_ra  = head_up;
              pend_d.front_from_mem = 1'b1;
            end else begin
              tail_d  = tail_dn;
              mem_re  = 1'b1;
              mem_ra  = tail_dn;
              pend_d.rear_from_mem = 1'b1;
            end
          end
        end
        ACT_NOP: pend_d.ok = 1'b1;
        default: pend_d.ok = 1'b0;
      endcase
    end else if (load_out) begin
      if (pend_q.front_from_mem) front_d = rd_data_q;
      if (pend_q.rear_from_mem)  rear_d  = rd_data_q;
    end
    if (cfg_we) begin
      head_d  = '0;
      tail_d  = '0;
      empty_d = 1'b1;
    end
  end

  // Result stage
  assign out_free  = !m_tvalid_q || m_axis_tready;
  assign load_out  = (state_q == S_DONE) && out_free;
  assign front_sel = pend_q.front_from_mem ? rd_data_q : front_q;
  assign rear_sel  = pend_q.rear_from_mem ? rd_data_q : rear_q;
  assign front_ext = 64'(front_sel);
  assign rear_ext  = 64'(rear_sel);

  always_comb begin
    m_tdata_d                        = '0;
    m_tdata_d[OutOkBit]              = pend_q.ok;
    m_tdata_d[OutFrontLsb +: ValueW] = empty_q ? EmptyValue : front_ext[ValueW-1:0];
    m_tdata_d[OutRearLsb +: ValueW]  = empty_q ? EmptyValue : rear_ext[ValueW-1:0];
    m_tdata_d[OutEmptyBit]           = empty_q;
    m_tdata_d[OutFullBit]            = full_now;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      capacity_q <= CapW'(DEPTH);
      head_q     <= '0;
      tail_q     <= '0;
      empty_q    <= 1'b1;
      pend_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
      pend_q  <= pend_d;
      if (cfg_we) capacity_q <= pwdata[CapW-1:0];
      if (load_out) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    rear_q  <= rear_d;
    if (load_out) m_tdata_q <= m_tdata_d;
  end

  // Word store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= in_word;
    if (mem_re) rd_data_q <= mem_q[mem_ra];
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

// ===== rtl/cdq_checker.sv =====
// Port-level checks for the circular deque, bound to the top level.
`timescale 1ns / 1ps
module cdq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [cdq_pkg::OutDataW-1:0]  m_axis_tdata
);
  import cdq_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] inflight_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // words taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != 2'd0)
    else $error("result word without an input word");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q != 2'd3)
    else $error("too many words in flight");

  a_empty_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[OutEmptyBit] |->
      m_axis_tdata[OutFrontLsb +: ValueW] == EmptyValue &&
      m_axis_tdata[OutRearLsb +: ValueW] == EmptyValue &&
      !m_axis_tdata[OutFullBit])
    else $error("empty deque shows data or full");

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for circular_deque_top: directed table, then random phases.
`timescale 1ns / 1ps
module tb_top;
  import cdq_pkg::*;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_AT     = 300;  // result count at which the sink stalls
  localparam int unsigned HOLD_CYCLES = 300;

  localparam logic [ActionW-1:0]  ACT_BAD_LO  = 3'd5;
  localparam logic [ActionW-1:0]  ACT_BAD_MID = 3'd6;
  localparam logic [ActionW-1:0]  ACT_BAD_HI  = 3'd7;
  localparam logic [CfgAddrW-1:0] CAP_ADDR    = '0;

  typedef struct packed {
    logic              ok;
    logic [ValueW-1:0] front;
    logic [ValueW-1:0] rear;
    logic              empty;
    logic              full;
  } deque_status_t;

  typedef struct packed {
    bit                 is_cfg;
    logic [31:0]        cfg_val;
    logic [ActionW-1:0] act;
    logic [ValueW-1:0]  val;
    bit                 typed;
    deque_status_t      res;
  } plan_row_t;

  localparam deque_status_t ST_EMPTY_OK   = {1'b1, EmptyValue, EmptyValue, 1'b1, 1'b0};
  localparam deque_status_t ST_EMPTY_FAIL = {1'b0, EmptyValue, EmptyValue, 1'b1, 1'b0};

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;  // action[2:0], value[34:3]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;        // ok[0], front[32:1], rear[64:33],
                                             // empty[65], full[66]
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [CfgAddrW-1:0]  paddr         = '0;
  logic [CfgDataW-1:0]  pwdata        = '0;
  logic [CfgDataW-1:0]  prdata;
  logic                 pready;

  circular_deque_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk_i = ~clk_i;

  // Deque shadow
  logic [ValueW-1:0] dq_mem [DEPTH];
  int unsigned       dq_head  = 0;
  int unsigned       dq_tail  = 0;
  bit                dq_empty = 1'b1;
  logic [CapW-1:0]   dq_cap   = CapW'(DEPTH);

  deque_status_t status_q [$];
  plan_row_t     plan [$];
  int unsigned   mismatches   = 0;
  int unsigned   results_seen = 0;
  int unsigned   cycle_count  = 0;
  bit            tx_calm      = 1'b0;
  bit            rx_calm      = 1'b0;

  function automatic int unsigned cap_in_use();
    if (dq_cap == '0) return 1;
    if (dq_cap > DEPTH) return DEPTH;
    return 32'(dq_cap);
  endfunction

  function automatic int unsigned wrap_inc(int unsigned idx, int unsigned cap);
    return (idx + 1 >= cap) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned wrap_dec(int unsigned idx, int unsigned cap);
    return (idx == 0 || idx >= cap) ? cap - 1 : idx - 1;
  endfunction

  function automatic bit deque_full(int unsigned cap);
    return !dq_empty && wrap_inc(dq_tail, cap) == dq_head;
  endfunction

  function automatic deque_status_t advance_deque(logic [ActionW-1:0] act,
                                                  logic [ValueW-1:0] val);
    int unsigned   cap;
    bit            ok;
    deque_status_t r;
    cap = cap_in_use();
    ok  = 1'b0;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (dq_empty) begin
          // first word always lands in entry 0
          dq_head   = 0;
          dq_tail   = 0;
          dq_empty  = 1'b0;
          dq_mem[0] = val;
          ok        = 1'b1;
        end else if (!deque_full(cap)) begin
          if (act == ACT_PUSH_FRONT) begin
            dq_head         = wrap_dec(dq_head, cap);
            dq_mem[dq_head] = val;
          end else begin
            dq_tail         = wrap_inc(dq_tail, cap);
            dq_mem[dq_tail] = val;
          end
          ok = 1'b1;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (!dq_empty) begin
          if (dq_head == dq_tail) begin
            dq_head  = 0;
            dq_tail  = 0;
            dq_empty = 1'b1;
          end else if (act == ACT_POP_FRONT) begin
            dq_head = wrap_inc(dq_head, cap);
          end else begin
            dq_tail = wrap_dec(dq_tail, cap);
          end
          ok = 1'b1;
        end
      end
      ACT_NOP: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    r.ok    = ok;
    r.front = dq_empty ? EmptyValue : dq_mem[dq_head];
    r.rear  = dq_empty ? EmptyValue : dq_mem[dq_tail];
    r.empty = dq_empty;
    r.full  = deque_full(cap);
    return r;
  endfunction

  function automatic plan_row_t op(logic [ActionW-1:0] a, logic [ValueW-1:0] v);
    plan_row_t r;
    r     = '0;
    r.act = a;
    r.val = v;
    return r;
  endfunction

  function automatic plan_row_t op_exp(logic [ActionW-1:0] a, logic [ValueW-1:0] v,
                                       deque_status_t res);
    plan_row_t r;
    r       = op(a, v);
    r.typed = 1'b1;
    r.res   = res;
    return r;
  endfunction

  function automatic plan_row_t cfg(logic [31:0] v);
    plan_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one word; the expectation is queued at the accepting edge.
  task automatic send_word(logic [ActionW-1:0] act, logic [ValueW-1:0] val,
                           bit typed, deque_status_t typed_res);
    int unsigned   gap;
    deque_status_t pred;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, val, act};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = advance_deque(act, val);
    status_q.push_back(typed ? typed_res : pred);
  endtask

  // Capacity write only once the deque has drained its results; read back after.
  task automatic write_capacity(logic [31:0] v);
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CAP_ADDR;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    dq_cap   = v[CapW-1:0];
    dq_head  = 0;
    dq_tail  = 0;
    dq_empty = 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field("capacity", {{(32-CapW){1'b0}}, dq_cap}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic burst(int unsigned n, int unsigned push_pct, int unsigned pop_pct);
    int unsigned        r;
    logic [ActionW-1:0] act;
    logic [ValueW-1:0]  val;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 64 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 7))
        0:       val = 32'h7FFF_FFFF;
        1:       val = 32'h8000_0000;
        2:       val = 32'hFFFF_FFFF;
        3:       val = 32'h0000_0000;
        default: val = $urandom();
      endcase
      r = $urandom_range(0, 99);
      if (r < push_pct)
        act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      else if (r < push_pct + pop_pct)
        act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
      else if ($urandom_range(0, 1))
        act = ACT_NOP;
      else
        act = ActionW'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
      send_word(act, val, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : result_sink
    int unsigned   gap;
    deque_status_t want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = rx_calm ? 0 : $urandom_range(0, 11);
      if (results_seen == HOLD_AT) gap = HOLD_CYCLES;  // long stall to back up the input
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_seen++;
      if (status_q.size() == 0) begin
        $error("result word with nothing outstanding");
        mismatches++;
      end else begin
        want = status_q.pop_front();
        check_field("ok", 32'(want.ok), 32'(m_axis_tdata[OutOkBit]));
        check_field("front_value", want.front, m_axis_tdata[OutFrontLsb +: ValueW]);
        check_field("rear_value", want.rear, m_axis_tdata[OutRearLsb +: ValueW]);
        check_field("is_empty", 32'(want.empty), 32'(m_axis_tdata[OutEmptyBit]));
        check_field("is_full", 32'(want.full), 32'(m_axis_tdata[OutFullBit]));
      end
    end
  end

  initial begin : stimulus
    logic [31:0] caps [10];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty deque after reset, then extremes at full capacity
    plan.push_back(op_exp(ACT_POP_FRONT, 32'h1111_1111, ST_EMPTY_FAIL));
    plan.push_back(op_exp(ACT_POP_BACK, 32'h0000_0000, ST_EMPTY_FAIL));
    plan.push_back(op_exp(ACT_NOP, 32'hFFFF_FFFF, ST_EMPTY_OK));
    plan.push_back(op_exp(ACT_BAD_LO, 32'h0000_0000, ST_EMPTY_FAIL));
    plan.push_back(op_exp(ACT_BAD_HI, 32'hDEAD_BEEF, ST_EMPTY_FAIL));
    plan.push_back(op_exp(ACT_PUSH_BACK, 32'h7FFF_FFFF,
                          {1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0}));
    plan.push_back(op(ACT_PUSH_FRONT, 32'h8000_0000));
    plan.push_back(op(ACT_PUSH_BACK, 32'hFFFF_FFFF));
    plan.push_back(op(ACT_PUSH_FRONT, 32'h0000_0000));
    plan.push_back(op(ACT_BAD_MID, 32'h5555_5555));
    plan.push_back(op(ACT_NOP, 32'hAAAA_AAAA));
    plan.push_back(op(ACT_POP_FRONT, 32'h0000_0001));
    plan.push_back(op(ACT_POP_BACK, 32'hFFFF_FFFE));
    plan.push_back(op(ACT_POP_FRONT, 32'h0000_0000));
    plan.push_back(op(ACT_POP_BACK, 32'h0000_0000));  // last word out
    // single-entry deque
    plan.push_back(cfg(32'd1));
    plan.push_back(op_exp(ACT_PUSH_FRONT, 32'h1234_5678,
                          {1'b1, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b1}));
    plan.push_back(op(ACT_PUSH_BACK, 32'h5A5A_5A5A));
    plan.push_back(op_exp(ACT_POP_BACK, 32'h0000_0000, ST_EMPTY_OK));
    plan.push_back(op(ACT_PUSH_BACK, 32'hA5A5_A5A5));
    // capacity write empties a non-empty deque
    plan.push_back(cfg(32'd2));
    plan.push_back(op_exp(ACT_POP_FRONT, 32'h0000_0000, ST_EMPTY_FAIL));
    plan.push_back(op(ACT_PUSH_BACK, 32'h0000_0001));
    plan.push_back(op(ACT_PUSH_FRONT, 32'h0000_0002));
    plan.push_back(op(ACT_PUSH_FRONT, 32'h0000_0003));
    plan.push_back(op(ACT_POP_BACK, 32'h0000_0000));

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        write_capacity(plan[i].cfg_val);
      else
        send_word(plan[i].act, plan[i].val, plan[i].typed, plan[i].res);
    end

    // oversized capacity acts as the full depth: fill past wrap, then drain part of it
    write_capacity(32'd2047);
    burst(1100, 96, 2);
    burst(160, 10, 85);

    caps = '{32'd1, 32'd0, 32'd2, 32'd3, 32'hFFFF_F805, 32'd1025, 32'd1024,
             $urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(17, 64)};
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      burst(50, 50, 40);
    end

    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
